// ===== hw/rtl/cmbl_pkg.sv =====
// Shared types and constants for the convolution MAC with batch norm and leaky activation.
`default_nettype none

package cmbl_pkg;

    // Default depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // Slope of the leaky activation: 0.1 in Q1.15.
    localparam logic signed [15:0] LEAKY_SLOPE_Q15 = 16'sd3276;

    // One classified product term as it waits in the queue.
    typedef struct packed {
        logic signed [31:0] prod;
        logic signed [15:0] coef_a;
        logic signed [15:0] coef_b;
        logic               last;
    } cmbl_entry_t;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        ST_ACC,
        ST_SCALE,
        ST_LEAKY,
        ST_OUT
    } cmbl_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cmbl_front.sv =====
// Front part: takes input beats, forms the activation-weight product and packs a queue entry.
`default_nettype none

module cmbl_front
    import cmbl_pkg::*;
(
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,
    input  wire logic        s_tlast,
    input  wire logic        q_full,
    output logic             q_push,
    output cmbl_entry_t      q_entry
);

    logic signed [15:0] act;
    logic signed [15:0] wgt;

    assign act      = s_tdata[15:0];
    assign wgt      = s_tdata[31:16];
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        q_entry.prod   = 32'(act) * 32'(wgt);
        q_entry.coef_a = s_tdata[47:32];
        q_entry.coef_b = s_tdata[63:48];
        q_entry.last   = s_tlast;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/cmbl_queue.sv =====
// Short register queue that decouples the front part from the back part.
`default_nettype none

module cmbl_queue
    import cmbl_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        push,
    input  wire cmbl_entry_t wr_entry,
    output logic             full,
    input  wire logic        pop,
    output cmbl_entry_t      rd_entry,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    cmbl_entry_t       mem_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     rd_ptr_reg;
    logic [CW-1:0]     count_reg;
    logic              do_push;
    logic              do_pop;

    assign full     = (count_reg == FULL_CNT);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign rd_entry = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/cmbl_back.sv =====
// Back part: accumulates products and forms each finished pixel through batch norm or bias.
`default_nettype none

module cmbl_back
    import cmbl_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        bn_enable,
    input  wire logic        q_empty,
    input  wire cmbl_entry_t q_entry,
    output logic             q_pop,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata
);

    cmbl_state_t        state_reg;
    cmbl_state_t        state_next;
    logic [31:0]        acc_reg;
    logic [31:0]        fin_reg;
    logic signed [15:0] ca_reg;
    logic signed [15:0] cb_reg;
    logic signed [31:0] mul_reg;
    logic [15:0]        nb_reg;
    logic signed [15:0] v_reg;
    logic signed [31:0] lk_reg;
    logic               out_valid_reg;
    logic [15:0]        out_data_reg;

    logic [31:0]        acc_sum;
    logic signed [15:0] scale_in;
    logic signed [15:0] bias_sum;
    logic [15:0]        pixel;
    logic               load_out;

    assign acc_sum  = acc_reg + q_entry.prod;
    assign scale_in = fin_reg[28:13];
    assign bias_sum = mul_reg[22:7] + cb_reg;

    always_comb begin
        if (!bn_enable) begin
            pixel = nb_reg;
        end else if (v_reg[15]) begin
            pixel = lk_reg[30:15];
        end else begin
            pixel = v_reg;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_ACC: begin
                if (!q_empty && q_entry.last) begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: state_next = ST_LEAKY;
            ST_LEAKY: state_next = ST_OUT;
            ST_OUT: begin
                if (!out_valid_reg || m_tready) begin
                    state_next = ST_ACC;
                end
            end
            default: state_next = ST_ACC;
        endcase
    end

    // Control outputs.
    always_comb begin
        q_pop    = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            ST_ACC:  q_pop    = !q_empty;
            ST_OUT:  load_out = !out_valid_reg || m_tready;
            default: begin
                q_pop    = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_ACC;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (q_pop) begin
                acc_reg <= q_entry.last ? '0 : acc_sum;
            end
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && q_entry.last) begin
            fin_reg <= acc_sum;
            ca_reg  <= q_entry.coef_a;
            cb_reg  <= q_entry.coef_b;
        end
        if (state_reg == ST_SCALE) begin
            mul_reg <= 32'(scale_in) * 32'(ca_reg);
            nb_reg  <= fin_reg[27:12] + ca_reg;
        end
        if (state_reg == ST_LEAKY) begin
            v_reg  <= bias_sum;
            lk_reg <= 32'(bias_sum) * 32'(LEAKY_SLOPE_Q15);
        end
        if (load_out) begin
            out_data_reg <= pixel;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/conv_mac_batchnorm_leaky_core.sv =====
// Top level of the convolution multiply-accumulate core with batch norm and leaky activation.
`default_nettype none

// Each input beat carries one product term: a Q8.8 activation and a Q4.12 weight. Their
// product is added into a 32-bit wrapping accumulator, and the beat flagged with s_tlast
// closes one output pixel, which leaves as a single Q8.8 beat on the master side while the
// accumulator starts again from zero. With bn_enable set, the pixel is accumulator bits
// 28:13 times coef_a (bits 22:7 kept), plus coef_b, and a negative value is then scaled by
// 0.1; with bn_enable clear it is accumulator bits 27:12 plus coef_a. A beat that does not
// close a pixel is just added in the back end's accumulator; a closing beat is added, then
// goes through scale multiply, bias add with leaky multiply and output load, since the scale
// and leaky multipliers each sit between registers; no beat leaves the queue meanwhile. The
// input queue (QUEUE_DEPTH entries) keeps taking beats during those steps, and the output
// register keeps the back end running while a finished pixel waits on m_tready, until the
// next pixel reaches output load. bn_enable is written through cfg_we/cfg_wdata and should
// only change while the core is idle.
module conv_mac_batchnorm_leaky_core
    import cmbl_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // Configuration: bn_enable.
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata,

    // Product-term input.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // activation, weight, coef_a, coef_b
    input  wire logic        s_tlast,   // last_product

    // Pixel output.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // pixel_out
);

    logic        bn_enable_reg;
    logic        q_push;
    logic        q_pop;
    logic        q_full;
    logic        q_empty;
    cmbl_entry_t wr_entry;
    cmbl_entry_t rd_entry;

    // The mode register resets to batch-norm mode and keeps only bit 0 of a write.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bn_enable_reg <= 1'b1;
        end else if (cfg_we) begin
            bn_enable_reg <= cfg_wdata;
        end
    end

    // The front end forms the product as the beat arrives, so the queue holds products.
    cmbl_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (wr_entry)
    );

    cmbl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .wr_entry (wr_entry),
        .full     (q_full),
        .pop      (q_pop),
        .rd_entry (rd_entry),
        .empty    (q_empty)
    );

    // The back end owns the accumulator and the pixel formation sequence.
    cmbl_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .bn_enable (bn_enable_reg),
        .q_empty   (q_empty),
        .q_entry   (rd_entry),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for the convolution MAC core with batch norm and leaky activation.
`timescale 1ns / 100ps

module tb_top;
    import cmbl_pkg::*;

    // A run of this many cycles with no beat moving on either side ends the run as hung.
    localparam int QUIET_LIMIT = 3000;
    // Length of the long receiver hold-off that backs the core up into its input queue.
    localparam int HOLD_CYCLES = 400;
    // Cycles allowed after the last expected pixel for product beats still in the queue.
    localparam int SETTLE_CYCLES = 8;
    // Leaky slope, 0.1 in Q1.15.
    localparam logic signed [15:0] LEAK_Q15 = 16'sd3276;

    // One product term as it travels on the slave side.
    typedef struct {
        logic signed [15:0] act;
        logic signed [15:0] wgt;
        logic signed [15:0] coef_a;
        logic signed [15:0] coef_b;
        logic               last;
    } term_t;

    // One row of the directed table: the term, the bn_enable value it runs under and,
    // where the pixel is obvious, the pixel typed in by hand.
    typedef struct {
        term_t       term;
        bit          bn;
        bit          typed;
        logic [15:0] pixel;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    // Shadow copy of the core's accumulator and of bn_enable.
    logic [31:0] mac_sum = '0;
    bit          bn_on = 1'b1;

    logic [15:0] expected_pixels[$];
    dir_row_t    dir_rows[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_token = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int error_count = 0;
    int beats_sent = 0;
    int pixels_seen = 0;
    int pixels_sent = 0;
    int cfg_writes = 0;

    conv_mac_batchnorm_leaky_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Adds one term into the shadow accumulator. On a closing term it forms the pixel,
    // clears the accumulator and returns 1.
    function automatic bit fold_term(input term_t t, output logic [15:0] px);
        logic signed [31:0] prod;
        logic signed [31:0] scaled;
        logic signed [31:0] leak;
        logic signed [15:0] top;
        logic signed [15:0] sum;
        prod = t.act * t.wgt;
        mac_sum = mac_sum + prod;
        px = '0;
        if (!t.last) begin
            return 1'b0;
        end
        if (bn_on) begin
            // Scale, bias, then the leaky slope on a negative result; all sums wrap.
            top = mac_sum[28:13];
            scaled = top * t.coef_a;
            sum = scaled[22:7] + t.coef_b;
            if (sum[15]) begin
                leak = sum * LEAK_Q15;
                sum = leak[30:15];
            end
        end else begin
            sum = mac_sum[27:12] + t.coef_a;
        end
        mac_sum = '0;
        px = sum;
        return 1'b1;
    endfunction

    function automatic void add_row(input bit bn, input logic [15:0] a, input logic [15:0] w,
                                    input logic [15:0] ca, input logic [15:0] cb,
                                    input bit last, input bit typed, input logic [15:0] px);
        dir_row_t r;
        r.term.act = a;
        r.term.wgt = w;
        r.term.coef_a = ca;
        r.term.coef_b = cb;
        r.term.last = last;
        r.bn = bn;
        r.typed = typed;
        r.pixel = px;
        dir_rows.push_back(r);
    endfunction

    // Random 16-bit value, weighted toward the extremes and toward small magnitudes.
    function automatic logic [15:0] pick16();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            4, 5: return 16'($urandom_range(511)) - 16'd256;
            default: return 16'($urandom);
        endcase
    endfunction

    // Offers one beat, idling first at the current rate, and records the expected pixel
    // once the beat is taken.
    task automatic send_beat(input term_t t, input bit typed, input logic [15:0] typed_px);
        logic [15:0] px;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {t.coef_b, t.coef_a, t.wgt, t.act};
        s_tlast <= t.last;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        beats_sent++;
        if (fold_term(t, px)) begin
            expected_pixels.push_back(typed ? typed_px : px);
            pixels_sent++;
        end
    endtask

    // Waits until every expected pixel has left and the queue has had time to drain.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_bn(input bit en);
        cfg_we <= 1'b1;
        cfg_wdata <= en;
        @(posedge aclk);
        cfg_we <= 1'b0;
        bn_on = en;
        cfg_writes++;
    endtask

    task automatic send_pixel(input int n_terms);
        term_t t;
        for (int i = 0; i < n_terms; i++) begin
            t.act = pick16();
            t.wgt = pick16();
            t.coef_a = pick16();
            t.coef_b = pick16();
            t.last = (i == n_terms - 1);
            send_beat(t, 1'b0, 16'h0000);
        end
    endtask

    // Random whole pixels under one bn_enable setting; the pressure flag starts the long
    // receiver hold-off right after the register write.
    task automatic run_segment(input int n_items, input bit bn, input bit pressure);
        int sent;
        int len;
        sent = 0;
        wait_idle();
        set_bn(bn);
        if (pressure) begin
            hold_token <= hold_token + 1;
        end
        while (sent < n_items) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(6, 1);
            send_pixel(len);
            sent += len;
        end
    endtask

    // Receiver: random stalls at the phase's rate, or a long hold-off when one is asked for.
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Every pixel beat is compared with the oldest expected pixel.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            pixels_seen++;
            if (expected_pixels.size() == 0) begin
                error_count++;
                if (error_count <= 10) begin
                    $display("Unexpected pixel beat: got %h", m_tdata);
                end
            end else begin
                if (m_tdata !== expected_pixels[0]) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $display("Pixel mismatch at pixel %0d: expected %h, got %h",
                                 pixels_seen, expected_pixels[0], m_tdata);
                    end
                end
                void'(expected_pixels.pop_front());
            end
        end
    end

    // Watchdog on cycles where no beat moves on either side.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no beat moved for %0d cycles", QUIET_LIMIT);
            $display("[conv_mac_batchnorm_leaky_core] ERROR");
            $finish;
        end
    end

    initial begin
        // Directed table. Batch-norm rows come first, running on the reset value of bn_enable.
        // Empty accumulator: the scale sees zero, so the pixel is just the bias.
        add_row(1, 16'h0000, 16'h0000, 16'h7FFF, 16'h1234, 1, 1, 16'h1234);
        // Most negative bias through the leaky slope: -32768 * 0.1 = -3276.
        add_row(1, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 1, 1, 16'hF334);
        // -1 through the slope rounds down and stays -1.
        add_row(1, 16'h0000, 16'h0000, 16'h0001, 16'hFFFF, 1, 1, 16'hFFFF);
        // Extreme products, with coefficients on non-closing beats that must be ignored.
        add_row(1, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 0, 0, 16'h0000);
        add_row(1, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0, 0, 16'h0000);
        add_row(1, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 1, 0, 16'h0000);
        // 1.0 times 1.0, scaled by 1.0, no bias.
        add_row(1, 16'h0100, 16'h1000, 16'h0100, 16'h0000, 1, 1, 16'h0100);
        // -1.0 times 1.0 gives a negative value for the leaky slope.
        add_row(1, 16'hFF00, 16'h1000, 16'h0100, 16'h0000, 1, 0, 16'h0000);
        // Bias sum that wraps into the sign bit.
        add_row(1, 16'h0100, 16'h1000, 16'h0100, 16'h7FFF, 1, 0, 16'h0000);
        // Bias-only rows: coef_b is ignored.
        add_row(0, 16'h0000, 16'h0000, 16'h7FFF, 16'h1234, 1, 1, 16'h7FFF);
        add_row(0, 16'h0000, 16'h0000, 16'h8000, 16'hFFFF, 1, 1, 16'h8000);
        // Four products of 2^30 wrap the accumulator back to zero.
        add_row(0, 16'h8000, 16'h8000, 16'h1111, 16'h2222, 0, 0, 16'h0000);
        add_row(0, 16'h8000, 16'h8000, 16'h3333, 16'h4444, 0, 0, 16'h0000);
        add_row(0, 16'h8000, 16'h8000, 16'h5555, 16'h6666, 0, 0, 16'h0000);
        add_row(0, 16'h8000, 16'h8000, 16'h0055, 16'h7777, 1, 1, 16'h0055);
        add_row(0, 16'h0100, 16'h1000, 16'h0000, 16'h7FFF, 1, 1, 16'h0100);
        // Bias sum that wraps in bias-only mode.
        add_row(0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000, 1, 0, 16'h0000);
        add_row(0, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 1, 0, 16'h0000);
        // Back to batch norm with negative extremes everywhere.
        add_row(1, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 1, 0, 16'h0000);
        add_row(1, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 1, 0, 16'h0000);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 20;
        recv_stall_pct <= 20;
        foreach (dir_rows[i]) begin
            if (dir_rows[i].bn != bn_on) begin
                wait_idle();
                set_bn(dir_rows[i].bn);
            end
            send_beat(dir_rows[i].term, dir_rows[i].typed, dir_rows[i].pixel);
        end

        // Four handshake mixes, each run under both bn_enable values.
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
                1: begin send_idle_pct = 55; recv_stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct <= 55; end
                default: begin send_idle_pct = 31; recv_stall_pct <= 31; end
            endcase
            run_segment(178, p[0] ? 1'b0 : 1'b1, p == 0);
            run_segment(178, p[0] ? 1'b1 : 1'b0, 1'b0);
        end

        wait_idle();
        if (expected_pixels.size() != 0) begin
            error_count++;
            $display("%0d expected pixels never arrived", expected_pixels.size());
        end

        $display("Run covered %0d product beats closing %0d pixels, %0d bn_enable writes,",
                 beats_sent, pixels_sent, cfg_writes);
        $display("four idle and stall mixes and one long output hold-off; %0d mismatches.",
                 error_count);
        if (error_count == 0) begin
            $display("[conv_mac_batchnorm_leaky_core] OK");
        end else begin
            $display("[conv_mac_batchnorm_leaky_core] ERROR");
        end
        $finish;
    end

endmodule
